@@ hw/rtl/xcfr_pkg.sv @@
// Shared types and constants of the XOR-checked frame receiver.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package xcfr_pkg;

    // Largest payload length the receiver ever accepts
    localparam int MAX_PAYLOAD = 256;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_MARKER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 2'd2;

    localparam logic [8:0] LENGTH_LIMIT_RESET = 9'd256;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5,
        PH_STOP    = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_BYTE     = 3'd1,
        EV_ACCEPT   = 3'd2,
        EV_BAD      = 3'd3,
        EV_TOO_LONG = 3'd4,
        EV_OVERRUN  = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] stop_marker;
        logic [8:0] length_limit;
    } cfg_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  message_type;
        logic [15:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/xcfr_cfg.sv @@
// Configuration register file of the frame receiver.
// Depends on xcfr_pkg for register indexes and the cfg_t struct.
`default_nettype none

module xcfr_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [xcfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data,
    output xcfr_pkg::cfg_t                      cfg
);
    import xcfr_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker <= 8'd0;
            cfg_reg.stop_marker  <= 8'd0;
            cfg_reg.length_limit <= LENGTH_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_MARKER: cfg_reg.start_marker <= cfg_data[7:0];
                REG_STOP_MARKER:  cfg_reg.stop_marker  <= cfg_data[7:0];
                REG_LENGTH_LIMIT: cfg_reg.length_limit <= cfg_data[8:0];
                default:          ;  // drop writes beyond the register list
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/xcfr_parser.sv @@
// Frame parsing state machine and checksum datapath.
// Depends on xcfr_pkg for phase and event codes and the cfg_t / result_t structs.
`default_nettype none

module xcfr_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire xcfr_pkg::cfg_t    cfg,
    input  wire logic              accept,
    input  wire logic              func,
    input  wire logic [7:0]        rx_byte,
    output xcfr_pkg::result_t      result
);
    import xcfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] exp_len_reg, exp_len_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  check_reg, check_next;
    event_t      ev;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;

    logic [15:0] limit;
    logic [15:0] len_full;
    logic [8:0]  count_inc;

    assign limit = (16'(cfg.length_limit) > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD)
                                                               : 16'(cfg.length_limit);
    assign len_full  = {rx_byte, exp_len_reg[7:0]};
    assign count_inc = count_reg + 9'd1;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (func)
            phase_next = PH_WAIT;
        else
        begin
            case (phase_reg)
                PH_WAIT:    if (rx_byte == cfg.start_marker) phase_next = PH_LEN_LO;
                PH_LEN_LO:  phase_next = PH_LEN_HI;
                PH_LEN_HI:  phase_next = (len_full > limit) ? PH_WAIT : PH_TYPE;
                PH_TYPE:    phase_next = (exp_len_reg == 16'd0) ? PH_CHECK : PH_PAYLOAD;
                PH_PAYLOAD: if (16'(count_inc) >= exp_len_reg) phase_next = PH_CHECK;
                PH_CHECK:   phase_next = PH_STOP;
                PH_STOP:    phase_next = PH_WAIT;
                default:    phase_next = PH_WAIT;
            endcase
        end
    end

    // Frame fields and event
    always_comb
    begin
        exp_len_next = exp_len_reg;
        count_next   = count_reg;
        type_next    = type_reg;
        xor_next     = xor_reg;
        check_next   = check_reg;
        ev           = EV_NONE;
        data_byte    = 8'd0;
        byte_index   = 8'd0;
        if (func)
        begin
            exp_len_next = 16'd0;
            count_next   = 9'd0;
            type_next    = 8'd0;
            xor_next     = 8'd0;
            check_next   = 8'd0;
            ev           = EV_OVERRUN;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == cfg.start_marker)
                    begin
                        exp_len_next = 16'd0;
                        count_next   = 9'd0;
                        type_next    = 8'd0;
                        xor_next     = 8'd0;
                        check_next   = 8'd0;
                    end
                end
                PH_LEN_LO:
                begin
                    exp_len_next = {8'd0, rx_byte};
                    xor_next     = xor_reg ^ rx_byte;
                end
                PH_LEN_HI:
                begin
                    exp_len_next = len_full;
                    xor_next     = xor_reg ^ rx_byte;
                    if (len_full > limit)
                        ev = EV_TOO_LONG;
                end
                PH_TYPE:
                begin
                    type_next = rx_byte;
                    xor_next  = xor_reg ^ rx_byte;
                end
                PH_PAYLOAD:
                begin
                    ev         = EV_BYTE;
                    data_byte  = rx_byte;
                    byte_index = count_reg[7:0];
                    count_next = count_inc;
                    xor_next   = xor_reg ^ rx_byte;
                end
                PH_CHECK:
                    check_next = rx_byte;
                PH_STOP:
                    ev = (rx_byte == cfg.stop_marker && xor_reg == check_reg) ? EV_ACCEPT
                                                                               : EV_BAD;
                default:
                    ;
            endcase
        end
    end

    assign result.ev           = ev;
    assign result.data_byte    = data_byte;
    assign result.byte_index   = byte_index;
    assign result.message_type = type_next;
    assign result.frame_length = exp_len_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            exp_len_reg <= 16'd0;
            count_reg   <= 9'd0;
            type_reg    <= 8'd0;
            xor_reg     <= 8'd0;
            check_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            count_reg   <= count_next;
            type_reg    <= type_next;
            xor_reg     <= xor_next;
            check_reg   <= check_next;
        end
    end

    a_overrun_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func |=> phase_reg == PH_WAIT && exp_len_reg == 16'd0 && xor_reg == 8'd0)
        else $error("overrun left frame state behind");

    a_payload_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> exp_len_reg != 16'd0 && 16'(count_reg) < exp_len_reg)
        else $error("payload count outside declared length");

    a_length_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TYPE |-> exp_len_reg <= 16'(MAX_PAYLOAD))
        else $error("frame length above the hard limit reached the type phase");

endmodule

`default_nettype wire

@@ hw/rtl/xcfr_out.sv @@
// Result register between the parser and the master-side stream.
// Depends on xcfr_pkg for the result_t struct.
`default_nettype none

module xcfr_out (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire xcfr_pkg::result_t result_in,
    input  wire logic          take,
    output logic               can_load,
    output logic               valid,
    output xcfr_pkg::result_t  result_out
);
    import xcfr_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Refill in the same cycle the held result is taken
    assign can_load   = !valid_reg || take;
    assign valid_next = load || (valid_reg && !take);
    assign valid      = valid_reg;
    assign result_out = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

endmodule

`default_nettype wire

@@ hw/rtl/xor_checked_frame_receiver_unit.sv @@
// Top level of the XOR-checked frame receiver: config registers, parser, result register.
// Depends on xcfr_pkg, xcfr_cfg, xcfr_parser and xcfr_out.
//
// Channel   Dir  Signals                      Content
// s_*       in   tvalid/tready/tdata/tuser    received byte (tdata) or overrun flag (tuser)
// m_*       out  tvalid/tready/tdata/tuser    one result per transfer, event code in tuser
// cfg_*     in   valid/ready/index/data       register writes, index 0..2
//
// Results: one input transfer gives one result transfer, registered and shown in the following cycle.
// A new byte is taken every cycle unless stalled; the frame state machine updates on each accepted byte.
// Stalls: s_tready drops only while a result is held and m_tready is low; a held
// result is replaced in the same cycle it is taken, so a ready sink sees full rate.
// Reset: rst_n clears the phase to waiting for a start byte, zeroes the frame fields
// and restores the config defaults (start 0, stop 0, length limit 256).
`default_nettype none

module xor_checked_frame_receiver_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  wire logic                           s_tuser,   // [0] func (1 = overrun)
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] data_byte, [15:8] byte_index, [23:16] message_type, [39:24] frame_length
    output logic [39:0]                         m_tdata,
    output logic [2:0]                          m_tuser,   // [2:0] event_res
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [xcfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                    cfg_data
);
    import xcfr_pkg::*;

    cfg_t    cfg;
    result_t parse_res;
    result_t held_res;
    logic    in_xfer;

    // Advance the parser only on an input transfer
    assign in_xfer = s_tvalid && s_tready;

    xcfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xcfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (in_xfer),
        .func    (s_tuser),
        .rx_byte (s_tdata),
        .result  (parse_res)
    );

    xcfr_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_xfer),
        .result_in  (parse_res),
        .take       (m_tready),
        .can_load   (s_tready),
        .valid      (m_tvalid),
        .result_out (held_res)
    );

    assign m_tuser = held_res.ev;
    assign m_tdata = {held_res.frame_length, held_res.message_type,
                      held_res.byte_index, held_res.data_byte};

    a_overrun_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> m_tvalid && m_tuser == EV_OVERRUN
                                            && m_tdata[39:16] == 24'd0)
        else $error("overrun transfer did not produce a cleared overrun result");

    a_index_below_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_BYTE |-> 16'(m_tdata[15:8]) < m_tdata[39:24])
        else $error("payload byte index not below frame length");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule

`default_nettype wire
